@@ src/vdrc_pkg.sv @@
// ----------------------------------------------------------------------------
// VRAM DMA controller package
// Shared types and constants for the VRAM DMA register controller.
// ----------------------------------------------------------------------------
`default_nettype none

package vdrc_pkg;

    // Request kinds.
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_HBLANK = 1'b1;

    // Register indexes.
    localparam logic [2:0] REG_SRC_HI = 3'd0;
    localparam logic [2:0] REG_SRC_LO = 3'd1;
    localparam logic [2:0] REG_DST_HI = 3'd2;
    localparam logic [2:0] REG_DST_LO = 3'd3;
    localparam logic [2:0] REG_LENGTH = 3'd4;

    localparam int          BLOCK_BYTES = 16;
    localparam int          LEN_W       = 12;
    localparam logic [15:0] VRAM_BASE   = 16'h8000;
    localparam logic [7:0]  LOW_MASK    = 8'hF0;
    localparam logic [7:0]  DST_HI_MASK = 8'h1F;
    localparam logic [6:0]  LEN_LAST    = 7'h7F;

    typedef struct packed {
        logic             copy_valid;
        logic [15:0]      copy_src;
        logic [15:0]      copy_dst;
        logic [LEN_W-1:0] copy_len;
        logic             busy_res;
        logic [7:0]       length_reg;
    } t_result;

endpackage

`default_nettype wire

@@ src/vdrc_if.sv @@
// ----------------------------------------------------------------------------
// VRAM DMA controller channels
// Request and result channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface vdrc_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [2:0] reg_sel;
    logic [7:0] write_data;
    logic       lcd_on;

    modport source (output valid, req_type, reg_sel, write_data, lcd_on, input ready);
    modport sink   (input valid, req_type, reg_sel, write_data, lcd_on, output ready);
endinterface

interface vdrc_out_if;
    logic        valid;
    logic        ready;
    logic        copy_valid;
    logic [15:0] copy_src;
    logic [15:0] copy_dst;
    logic [11:0] copy_len;
    logic        busy_res;
    logic [7:0]  length_reg;

    modport source (output valid, copy_valid, copy_src, copy_dst, copy_len, busy_res,
                    length_reg, input ready);
    modport sink   (input valid, copy_valid, copy_src, copy_dst, copy_len, busy_res,
                    length_reg, output ready);
endinterface

`default_nettype wire

@@ src/vdrc_skid.sv @@
// ----------------------------------------------------------------------------
// VRAM DMA controller result buffer
// Output register plus one skid entry, so an item is taken while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module vdrc_skid (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire vdrc_pkg::t_result i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output vdrc_pkg::t_result      o_data
);
    import vdrc_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    take_in;
    logic    take_out;

    assign o_ready  = !r_skid_valid;
    assign take_in  = i_valid && !r_skid_valid;
    assign take_out = r_out_valid && i_ready;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (take_out) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (take_in) begin
            // The new item goes to the output register when it is free after this edge.
            if (!n_out_valid) begin
                n_out       = i_data;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

`default_nettype wire

@@ src/vram_dma_register_controller_core.sv @@
// ----------------------------------------------------------------------------
// VRAM DMA register controller
// Holds the DMA registers and issues general and hblank copy descriptors.
// ----------------------------------------------------------------------------
// Usage:
// The request channel i_in carries one item per register write or hblank
// event. Each accepted item yields exactly one result on o_out, carrying a
// copy descriptor when the item starts a transfer, plus the active flag and
// the length/mode register after the item.
// The register update and the descriptor are computed in the cycle the item
// is accepted; the result goes to the output register, or to the skid entry
// if that is full. While the receiver takes results, throughput is one item
// per cycle, set by the single output register and a one-entry skid buffer
// behind it. When the receiver stalls, one more item is still taken into
// the skid entry; then i_in.ready drops until the output register drains.
// Reset clears all five registers, the active flag and both result slots.
// ----------------------------------------------------------------------------
`default_nettype none

module vram_dma_register_controller_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    vdrc_in_if.sink     i_in,
    vdrc_out_if.source  o_out
);
    import vdrc_pkg::*;

    logic [7:0] r_src_hi, n_src_hi;
    logic [7:0] r_src_lo, n_src_lo;
    logic [7:0] r_dst_hi, n_dst_hi;
    logic [7:0] r_dst_lo, n_dst_lo;
    logic [7:0] r_length, n_length;
    logic       r_active, n_active;

    logic             accept;
    logic             do_copy;
    logic [LEN_W-1:0] nbytes;
    logic [15:0]      src_addr;
    logic [15:0]      dst_addr;
    logic [15:0]      src_next;
    logic [15:0]      dst_next;
    logic [7:0]       len_dec;
    t_result          res;
    t_result          out_data;
    logic             buf_ready;

    assign accept   = i_in.valid && buf_ready;
    assign i_in.ready = buf_ready;

    assign src_addr = {r_src_hi, r_src_lo};
    assign dst_addr = VRAM_BASE | {r_dst_hi, r_dst_lo};
    assign src_next = src_addr + 16'(nbytes);
    assign dst_next = dst_addr + 16'(nbytes);
    assign len_dec  = r_length - 8'd1;

    always_comb begin
        n_src_hi = r_src_hi;
        n_src_lo = r_src_lo;
        n_dst_hi = r_dst_hi;
        n_dst_lo = r_dst_lo;
        n_length = r_length;
        n_active = r_active;
        do_copy  = 1'b0;
        nbytes   = LEN_W'(BLOCK_BYTES);

        if (i_in.req_type == REQ_WRITE) begin
            case (i_in.reg_sel)
                REG_SRC_HI: n_src_hi = i_in.write_data;
                REG_SRC_LO: n_src_lo = i_in.write_data;
                REG_DST_HI: n_dst_hi = i_in.write_data;
                REG_DST_LO: n_dst_lo = i_in.write_data;
                REG_LENGTH: begin
                    n_length = i_in.write_data;
                    if (r_active && !i_in.write_data[7]) begin
                        n_active = 1'b0;
                    end else if (i_in.write_data[7]) begin
                        n_active = 1'b1;
                    end else begin
                        // General transfer of (n+1) blocks, then the length clears.
                        do_copy  = 1'b1;
                        nbytes   = {LEN_W'({1'b0, i_in.write_data[6:0]}) + LEN_W'(1)}
                                   << $clog2(BLOCK_BYTES);
                        n_length = 8'd0;
                    end
                end
                default: ;
            endcase
        end else if (r_active && i_in.lcd_on) begin
            do_copy  = 1'b1;
            n_length = len_dec;
            if (len_dec[6:0] == LEN_LAST) begin
                n_active = 1'b0;
            end
        end

        if (do_copy) begin
            n_src_hi = src_next[15:8];
            n_src_lo = src_next[7:0] & LOW_MASK;
            n_dst_hi = dst_next[15:8] & DST_HI_MASK;
            n_dst_lo = dst_next[7:0] & LOW_MASK;
        end
    end

    always_comb begin
        res.copy_valid = do_copy;
        res.copy_src   = do_copy ? src_addr : 16'd0;
        res.copy_dst   = do_copy ? dst_addr : 16'd0;
        res.copy_len   = do_copy ? nbytes : '0;
        res.busy_res   = n_active;
        res.length_reg = n_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_hi <= 8'd0;
            r_src_lo <= 8'd0;
            r_dst_hi <= 8'd0;
            r_dst_lo <= 8'd0;
            r_length <= 8'd0;
            r_active <= 1'b0;
        end else if (accept) begin
            r_src_hi <= n_src_hi;
            r_src_lo <= n_src_lo;
            r_dst_hi <= n_dst_hi;
            r_dst_lo <= n_dst_lo;
            r_length <= n_length;
            r_active <= n_active;
        end
    end

    vdrc_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (buf_ready),
        .i_data  (res),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (out_data)
    );

    assign o_out.copy_valid = out_data.copy_valid;
    assign o_out.copy_src   = out_data.copy_src;
    assign o_out.copy_dst   = out_data.copy_dst;
    assign o_out.copy_len   = out_data.copy_len;
    assign o_out.busy_res   = out_data.busy_res;
    assign o_out.length_reg = out_data.length_reg;

    // A descriptor always targets VRAM and moves whole blocks.
    a_copy_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.copy_valid) |->
            (o_out.copy_dst[15] && o_out.copy_len[3:0] == 4'd0 && o_out.copy_len != '0))
        else $error("malformed copy descriptor");

    // Without a copy the descriptor fields stay zero.
    a_no_copy_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.copy_valid) |->
            (o_out.copy_src == 16'd0 && o_out.copy_dst == 16'd0 && o_out.copy_len == '0))
        else $error("descriptor fields set without a copy");

    // An hblank item that copies always advances the source address.
    a_hblank_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.req_type == REQ_HBLANK && r_active && i_in.lcd_on) |=>
            ({r_src_hi, r_src_lo} == (($past(src_addr) + 16'(BLOCK_BYTES)) & 16'hFFF0)))
        else $error("source address did not advance");

    // A cancel write leaves the transfer idle.
    a_cancel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.req_type == REQ_WRITE && i_in.reg_sel == REG_LENGTH
            && r_active && !i_in.write_data[7]) |=> !r_active)
        else $error("hblank transfer not cancelled");

endmodule

`default_nettype wire

@@ tb/vdrc_dma_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VRAM DMA controller checker
// Watches the request and result channels, keeps its own copy of the DMA
// registers to work out each result, and compares every result it sees,
// field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module vdrc_dma_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    vdrc_in_if        i_req,
    vdrc_out_if       i_res,
    output int        o_fail_count,
    output int        o_pending
);
    import vdrc_pkg::*;

    logic [7:0] src_hi_q;
    logic [7:0] src_lo_q;
    logic [7:0] dst_hi_q;
    logic [7:0] dst_lo_q;
    logic [7:0] len_mode_q;
    logic       active_q;

    t_result pending_results[$];

    // Emits the descriptor for the current addresses, then moves both
    // addresses past the block and masks them the way the hardware does.
    function automatic t_result issue_copy(input logic [LEN_W-1:0] nbytes);
        t_result     r;
        logic [15:0] sa;
        logic [15:0] da;
        sa           = {src_hi_q, src_lo_q};
        da           = VRAM_BASE | {dst_hi_q, dst_lo_q};
        r            = '0;
        r.copy_valid = 1'b1;
        r.copy_src   = sa;
        r.copy_dst   = da;
        r.copy_len   = nbytes;
        sa           = sa + {4'd0, nbytes};
        da           = da + {4'd0, nbytes};
        src_hi_q     = sa[15:8];
        src_lo_q     = sa[7:0] & LOW_MASK;
        dst_hi_q     = da[15:8] & DST_HI_MASK;
        dst_lo_q     = da[7:0] & LOW_MASK;
        return r;
    endfunction

    function automatic t_result next_dma_result(input logic req, input logic [2:0] sel,
                                                input logic [7:0] data, input logic lcd);
        t_result r;
        r = '0;
        if (req == REQ_WRITE) begin
            case (sel)
                REG_SRC_HI: src_hi_q = data;
                REG_SRC_LO: src_lo_q = data;
                REG_DST_HI: dst_hi_q = data;
                REG_DST_LO: dst_lo_q = data;
                REG_LENGTH: begin
                    len_mode_q = data;
                    if (active_q && !data[7]) begin
                        active_q = 1'b0;
                    end else if (data[7]) begin
                        active_q = 1'b1;
                    end else begin
                        r          = issue_copy(LEN_W'((int'(data[6:0]) + 1) * BLOCK_BYTES));
                        len_mode_q = '0;
                    end
                end
                default: ;
            endcase
        end else if (active_q && lcd) begin
            r          = issue_copy(LEN_W'(BLOCK_BYTES));
            len_mode_q = len_mode_q - 8'd1;
            if (len_mode_q[6:0] == LEN_LAST) begin
                active_q = 1'b0;
            end
        end
        r.busy_res   = active_q;
        r.length_reg = len_mode_q;
        return r;
    endfunction

    function automatic int field_differs(input string name, input logic [15:0] exp_v,
                                         input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result exp_r;
        t_result got_r;
        int      errs;
        if (!i_rst_n) begin
            src_hi_q     = '0;
            src_lo_q     = '0;
            dst_hi_q     = '0;
            dst_lo_q     = '0;
            len_mode_q   = '0;
            active_q     = 1'b0;
            o_fail_count = 0;
            pending_results.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                pending_results.push_back(next_dma_result(i_req.req_type, i_req.reg_sel,
                                                          i_req.write_data, i_req.lcd_on));
            end
            if (i_res.valid && i_res.ready) begin
                got_r.copy_valid = i_res.copy_valid;
                got_r.copy_src   = i_res.copy_src;
                got_r.copy_dst   = i_res.copy_dst;
                got_r.copy_len   = i_res.copy_len;
                got_r.busy_res   = i_res.busy_res;
                got_r.length_reg = i_res.length_reg;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual 0x%0h",
                             $time, got_r);
                    o_fail_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    errs  = field_differs("copy_valid", 16'(exp_r.copy_valid),
                                          16'(got_r.copy_valid))
                          + field_differs("copy_src", exp_r.copy_src, got_r.copy_src)
                          + field_differs("copy_dst", exp_r.copy_dst, got_r.copy_dst)
                          + field_differs("copy_len", 16'(exp_r.copy_len),
                                          16'(got_r.copy_len))
                          + field_differs("busy_res", 16'(exp_r.busy_res),
                                          16'(got_r.busy_res))
                          + field_differs("length_reg", 16'(exp_r.length_reg),
                                          16'(got_r.length_reg));
                    if (errs != 0) begin
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = pending_results.size();
    end

endmodule

@@ tb/tb_vram_dma_register_controller_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VRAM DMA register controller testbench
// Drives register writes and hblank events with random gaps and result
// stalls, including long output stalls that back up the request side.
// A directed opening covers the register extremes, unused indexes, general
// and hblank transfers, cancellation and address wrap; random well-formed
// transfer sequences with some noise follow. The checker does the comparing.
// ----------------------------------------------------------------------------

module tb_vram_dma_register_controller_core;
    import vdrc_pkg::*;

    localparam logic [2:0] REG_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REG_UNUSED_MID   = 3'd6;
    localparam logic [2:0] REG_UNUSED_LAST  = 3'd7;
    localparam int         WORK_ITEMS       = 850;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;

    // Sender and receiver pacing.
    bit   tx_calm;
    bit   rx_hold_req;
    bit   noise_phase;
    int   work_items;

    vdrc_in_if  req_ch ();
    vdrc_out_if res_ch ();

    always #2 clk = ~clk;

    vram_dma_register_controller_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    vdrc_dma_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Valid stays high across back-to-back items; it only drops for a gap.
    task automatic send_req(input logic req, input logic [2:0] sel, input logic [7:0] data,
                            input logic lcd);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= req;
        req_ch.reg_sel    <= sel;
        req_ch.write_data <= data;
        req_ch.lcd_on     <= lcd;
        do @(posedge clk); while (!req_ch.ready);
        if (!noise_phase) begin
            work_items++;
        end
    endtask

    task automatic send_hblank(input logic lcd);
        send_req(REQ_HBLANK, 3'($urandom_range(0, 7)), 8'($urandom), lcd);
    endtask

    task automatic set_addresses(input logic [15:0] src, input logic [15:0] dst);
        send_req(REQ_WRITE, REG_SRC_HI, src[15:8], 1'($urandom));
        send_req(REQ_WRITE, REG_SRC_LO, src[7:0], 1'($urandom));
        send_req(REQ_WRITE, REG_DST_HI, dst[15:8], 1'($urandom));
        send_req(REQ_WRITE, REG_DST_LO, dst[7:0], 1'($urandom));
    endtask

    initial begin : receiver
        int stall;
        int stretch_left;
        bit rx_calm;
        res_ch.ready <= 1'b0;
        stretch_left = 0;
        rx_calm      = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (stretch_left == 0) begin
                rx_calm      = ($urandom_range(0, 3) == 0);
                stretch_left = $urandom_range(10, 60);
            end
            stretch_left--;
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall       = $urandom_range(40, 90);
            end else begin
                stall = rx_calm ? 0 : $urandom_range(0, 12);
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    initial begin : stimulus
        int blocks;
        int events;
        int cut;
        int next_hold;
        int i;
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_WRITE;
        req_ch.reg_sel    <= REG_SRC_HI;
        req_ch.write_data <= '0;
        req_ch.lcd_on     <= 1'b0;
        tx_calm     = 1'b0;
        rx_hold_req = 1'b0;
        noise_phase = 1'b0;
        work_items  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Hblank events while idle, with the display on and off.
        send_req(REQ_HBLANK, REG_SRC_HI, 8'h00, 1'b1);
        send_req(REQ_HBLANK, REG_UNUSED_LAST, 8'hFF, 1'b0);
        // Full-scale register values keep their low bits until a transfer.
        set_addresses(16'hFFFF, 16'hFFFF);
        send_req(REQ_WRITE, REG_UNUSED_FIRST, 8'hAA, 1'b0);
        send_req(REQ_WRITE, REG_UNUSED_MID, 8'h55, 1'b1);
        send_req(REQ_WRITE, REG_UNUSED_LAST, 8'hFF, 1'b1);
        // Smallest general transfer wraps both addresses, then the largest.
        send_req(REQ_WRITE, REG_LENGTH, 8'h00, 1'b0);
        send_req(REQ_WRITE, REG_LENGTH, 8'h7F, 1'b1);
        set_addresses(16'h0000, 16'h0000);
        // Two-block hblank transfer with a display-off event before the first block.
        send_req(REQ_WRITE, REG_LENGTH, 8'h81, 1'b0);
        send_hblank(1'b0);
        send_hblank(1'b1);
        send_hblank(1'b1);
        send_hblank(1'b1);
        // Longest hblank transfer, cancelled after one block.
        send_req(REQ_WRITE, REG_LENGTH, 8'hFF, 1'b0);
        send_hblank(1'b1);
        send_req(REQ_WRITE, REG_LENGTH, 8'h05, 1'b1);
        send_req(REQ_WRITE, REG_LENGTH, 8'h80, 1'b0);
        send_hblank(1'b1);
        send_hblank(1'b1);

        next_hold = 150;
        while (work_items < WORK_ITEMS) begin
            tx_calm = ($urandom_range(0, 4) == 0);
            // Now and then stall the result side for a long stretch while
            // requests keep coming back to back.
            if (work_items >= next_hold) begin
                rx_hold_req = 1'b1;
                tx_calm     = 1'b1;
                next_hold   = next_hold + 300;
            end
            if ($urandom_range(0, 6) == 0) begin
                noise_phase = 1'b1;
                repeat ($urandom_range(1, 3)) begin
                    send_req(1'($urandom), 3'($urandom_range(0, 7)), 8'($urandom),
                             1'($urandom));
                end
                noise_phase = 1'b0;
            end
            if ($urandom_range(0, 9) < 7) begin
                set_addresses(16'($urandom), 16'($urandom));
            end
            if ($urandom_range(0, 1) == 0) begin
                blocks = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                     : $urandom_range(0, 7);
                send_req(REQ_WRITE, REG_LENGTH, {1'b0, 7'(blocks)}, 1'($urandom));
            end else begin
                blocks = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 127)
                                                      : $urandom_range(0, 6);
                send_req(REQ_WRITE, REG_LENGTH, {1'b1, 7'(blocks)}, 1'($urandom));
                events = blocks + 1 + $urandom_range(0, 2);
                if (events > 40) begin
                    events = 40;
                end
                cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, events) : events;
                for (i = 0; i < cut; i++) begin
                    send_hblank($urandom_range(0, 6) != 0);
                end
                if (cut < blocks + 1) begin
                    // Restart or cancel a transfer that is still running.
                    send_req(REQ_WRITE, REG_LENGTH, 8'($urandom), 1'($urandom));
                end
            end
        end

        // Drop valid at the edge that took the last item so it is not sent twice.
        req_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
